@@ sv/tmv_pkg.sv @@
// Shared types and constants for the triangular matrix-vector multiply core.
// No dependencies; used by every module of the block via scoped names.
package tmv_pkg;

  localparam int MAX_DIM = 64;
  localparam int IDX_W   = 6;
  localparam int DIM_W   = 7;
  localparam int DATA_W  = 32;
  localparam int MADDR_W = 2 * IDX_W;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int TERM_W  = PROD_W - 16;
  localparam int ACC_W   = TERM_W + IDX_W;
  localparam int PADDR_W = 4;

  localparam logic [1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] OP_LOAD_VECTOR = 2'd1;
  localparam logic [1:0] OP_MULTIPLY    = 2'd2;

  localparam logic [1:0] REG_LOWER     = 2'd0;
  localparam logic [1:0] REG_TRANSPOSE = 2'd1;
  localparam logic [1:0] REG_UNIT_DIAG = 2'd2;
  localparam logic [1:0] REG_DIMENSION = 2'd3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] result;
    logic                     saturated;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic             lower;
    logic             transpose;
    logic             unit_diag;
    logic [DIM_W-1:0] dimension;
  } cfg_t;

  // sequencer -> datapath
  typedef struct packed {
    logic               ld_mat;
    logic               ld_vec;
    logic               mac_v;
    logic [MADDR_W-1:0] maddr;
    logic [IDX_W-1:0]   vaddr;
    logic               diag;
    logic               row_end;
    logic               run_end;
    logic [IDX_W-1:0]   k;
    logic               cp_rd;
    logic [IDX_W-1:0]   cp_idx;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic pipe_busy;
    logic wb_pending;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_COPY  = 4'b1000
  } state_t;

endpackage

@@ sv/tmv_cfg.sv @@
// APB-style configuration registers: triangle, transpose, unit diagonal, dimension.
// Depends on tmv_pkg.
module tmv_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmv_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output tmv_pkg::cfg_t                cfg
);

  tmv_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        tmv_pkg::REG_LOWER:     cfg_nxt.lower     = pwdata[0];
        tmv_pkg::REG_TRANSPOSE: cfg_nxt.transpose = pwdata[0];
        tmv_pkg::REG_UNIT_DIAG: cfg_nxt.unit_diag = pwdata[0];
        tmv_pkg::REG_DIMENSION: cfg_nxt.dimension = pwdata[tmv_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tmv_pkg::REG_LOWER:     prdata = {31'd0, cfg_r.lower};
      tmv_pkg::REG_TRANSPOSE: prdata = {31'd0, cfg_r.transpose};
      tmv_pkg::REG_UNIT_DIAG: prdata = {31'd0, cfg_r.unit_diag};
      tmv_pkg::REG_DIMENSION: prdata = {{(32-tmv_pkg::DIM_W){1'b0}}, cfg_r.dimension};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lower     <= 1'b0;
      cfg_r.transpose <= 1'b0;
      cfg_r.unit_diag <= 1'b0;
      cfg_r.dimension <= tmv_pkg::DIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ sv/tmv_seq.sv @@
// Sequencer: decodes transactions, walks the triangle one MAC per cycle,
// then runs the result-to-vector copy pass. Depends on tmv_pkg.
module tmv_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  tmv_pkg::in_t       in_data,
  input  tmv_pkg::cfg_t      cfg,
  input  tmv_pkg::dp_stat_t  stat,
  output logic               busy,
  output tmv_pkg::ctl_t      ctl
);

  tmv_pkg::state_t              state_r, state_nxt;
  logic [tmv_pkg::IDX_W-1:0]    k_r, k_nxt;
  logic [tmv_pkg::IDX_W-1:0]    m_r, m_nxt;
  logic [tmv_pkg::IDX_W-1:0]    n_last;
  logic [tmv_pkg::IDX_W-1:0]    m_end;
  logic                         low_range;
  logic                         accept;

  // dimension 64..127 clamps to 64
  assign n_last    = cfg.dimension[tmv_pkg::DIM_W-1] ? tmv_pkg::IDX_W'(tmv_pkg::MAX_DIM - 1)
                                                     : cfg.dimension[tmv_pkg::IDX_W-1:0] - 1'b1;
  // columns 0..k of each row, else k..n-1
  assign low_range = cfg.lower ^ cfg.transpose;
  assign m_end     = low_range ? k_r : n_last;

  assign busy   = (state_r != tmv_pkg::S_IDLE) || stat.wb_pending;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    m_nxt     = m_r;
    ctl       = '0;
    ctl.ld_mat = accept && (in_data.operation == tmv_pkg::OP_LOAD_MATRIX);
    ctl.ld_vec = accept && (in_data.operation == tmv_pkg::OP_LOAD_VECTOR);
    ctl.maddr  = cfg.transpose ? {m_r, k_r} : {k_r, m_r};
    ctl.vaddr  = m_r;
    ctl.k      = k_r;
    ctl.cp_idx = m_r;
    case (state_r)
      tmv_pkg::S_IDLE: begin
        if (accept && (in_data.operation == tmv_pkg::OP_MULTIPLY) &&
            (cfg.dimension != '0)) begin
          state_nxt = tmv_pkg::S_MAC;
          k_nxt     = '0;
          m_nxt     = '0;
        end
      end
      tmv_pkg::S_MAC: begin
        ctl.mac_v   = 1'b1;
        ctl.diag    = cfg.unit_diag && (m_r == k_r);
        ctl.row_end = (m_r == m_end);
        ctl.run_end = (m_r == m_end) && (k_r == n_last);
        if (m_r == m_end) begin
          if (k_r == n_last) begin
            state_nxt = tmv_pkg::S_DRAIN;
          end else begin
            k_nxt = k_r + 1'b1;
            m_nxt = low_range ? '0 : k_r + 1'b1;
          end
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
      tmv_pkg::S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = tmv_pkg::S_COPY;
          m_nxt     = '0;
        end
      end
      tmv_pkg::S_COPY: begin
        ctl.cp_rd = 1'b1;
        if (m_r == n_last) begin
          state_nxt = tmv_pkg::S_IDLE;
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
      default: state_nxt = tmv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmv_pkg::S_IDLE;
      k_r     <= '0;
      m_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      m_r     <= m_nxt;
    end
  end

endmodule

@@ sv/tmv_dp.sv @@
// Datapath: matrix, vector and result memories, multiply stage, accumulator,
// saturation and result registers. Depends on tmv_pkg.
module tmv_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  tmv_pkg::in_t       in_data,
  input  tmv_pkg::ctl_t      ctl,
  output tmv_pkg::dp_stat_t  stat,
  output logic               out_strobe,
  output tmv_pkg::out_t      out_data
);

  logic signed [tmv_pkg::DATA_W-1:0] mat_mem [tmv_pkg::MAX_DIM*tmv_pkg::MAX_DIM];
  logic signed [tmv_pkg::DATA_W-1:0] vec_mem [tmv_pkg::MAX_DIM];
  logic signed [tmv_pkg::DATA_W-1:0] res_mem [tmv_pkg::MAX_DIM];

  logic signed [tmv_pkg::DATA_W-1:0] mat_q_r, vec_q_r, res_q_r;

  // stage 1: memory data valid
  logic                        s1_v_r, s1_diag_r, s1_row_end_r, s1_run_end_r;
  logic [tmv_pkg::IDX_W-1:0]   s1_k_r;
  // stage 2: term valid
  logic                        s2_v_r, s2_row_end_r, s2_run_end_r;
  logic [tmv_pkg::IDX_W-1:0]   s2_k_r;
  logic signed [tmv_pkg::TERM_W-1:0] term_r, term_nxt;
  logic signed [tmv_pkg::PROD_W-1:0] prod;

  logic signed [tmv_pkg::ACC_W-1:0]  acc_r, sum;
  logic signed [tmv_pkg::DATA_W-1:0] sat_val;
  logic                              clip;

  logic                        cp_v_r;
  logic [tmv_pkg::IDX_W-1:0]   cp_idx_r;

  logic                        out_strobe_r;
  tmv_pkg::out_t               out_data_r;

  // ---- memories ----
  always_ff @(posedge clk) begin
    if (ctl.ld_mat) begin
      mat_mem[{in_data.row, in_data.col}] <= in_data.value;
    end
    mat_q_r <= mat_mem[ctl.maddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_vec) begin
      vec_mem[in_data.row] <= in_data.value;
    end else if (cp_v_r) begin
      vec_mem[cp_idx_r] <= res_q_r;
    end
    vec_q_r <= vec_mem[ctl.vaddr];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_row_end_r) begin
      res_mem[s2_k_r] <= sat_val;
    end
    res_q_r <= res_mem[ctl.cp_idx];
  end

  // ---- multiply ----
  assign prod = mat_q_r * vec_q_r;

  // floor shift by 16 is an arithmetic drop of the low bits
  always_comb begin
    if (s1_diag_r) begin
      term_nxt = {{(tmv_pkg::TERM_W-tmv_pkg::DATA_W){vec_q_r[tmv_pkg::DATA_W-1]}}, vec_q_r};
    end else begin
      term_nxt = prod[tmv_pkg::PROD_W-1:16];
    end
  end

  // ---- accumulate and saturate ----
  assign sum  = acc_r + {{(tmv_pkg::ACC_W-tmv_pkg::TERM_W){term_r[tmv_pkg::TERM_W-1]}}, term_r};
  assign clip = !((&sum[tmv_pkg::ACC_W-1:tmv_pkg::DATA_W-1]) ||
                  !(|sum[tmv_pkg::ACC_W-1:tmv_pkg::DATA_W-1]));

  always_comb begin
    if (!clip) begin
      sat_val = sum[tmv_pkg::DATA_W-1:0];
    end else if (sum[tmv_pkg::ACC_W-1]) begin
      sat_val = {1'b1, {(tmv_pkg::DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(tmv_pkg::DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    term_r       <= term_nxt;
    s1_diag_r    <= ctl.diag;
    s1_row_end_r <= ctl.row_end;
    s1_run_end_r <= ctl.run_end;
    s1_k_r       <= ctl.k;
    s2_row_end_r <= s1_row_end_r;
    s2_run_end_r <= s1_run_end_r;
    s2_k_r       <= s1_k_r;
    cp_idx_r     <= ctl.cp_idx;
    out_data_r.index     <= s2_k_r;
    out_data_r.result    <= sat_val;
    out_data_r.saturated <= clip;
    out_data_r.last      <= s2_run_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      cp_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      acc_r        <= '0;
    end else begin
      s1_v_r       <= ctl.mac_v;
      s2_v_r       <= s1_v_r;
      cp_v_r       <= ctl.cp_rd;
      out_strobe_r <= s2_v_r && s2_row_end_r;
      if (s2_v_r) begin
        acc_r <= s2_row_end_r ? '0 : sum;
      end
    end
  end

  always_comb begin
    stat.pipe_busy  = s1_v_r || s2_v_r;
    stat.wb_pending = cp_v_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

@@ sv/triangular_matvec_multiply_core.sv @@
// Triangular matrix-vector multiply, signed Q16.16: x := A*x or A^T*x.
// Loads are accepted back to back while busy is low. A multiply issues one MAC a cycle over
// the triangle; each result passes the memory read, term and output registers after its
// row's last MAC. Then the pipeline drains, a copy pass moves the results into the vector
// memory and a write-back follows, with busy high. The result port cannot be stalled.
// Synchronous active-low reset clears control and config; the memories are not cleared.
module triangular_matvec_multiply_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  tmv_pkg::in_t                 in_data,
  output logic                         out_strobe,
  output tmv_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmv_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  tmv_pkg::cfg_t     cfg;
  tmv_pkg::ctl_t     ctl;
  tmv_pkg::dp_stat_t stat;

  tmv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tmv_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .cfg     (cfg),
    .stat    (stat),
    .busy    (busy),
    .ctl     (ctl)
  );

  tmv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
